// ===== design/tea_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the TEA block cipher.
// Used by the channel interfaces, the key registers, the round cells and the top level.
package tea_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CYCLE_COUNT_DEF = 32;

  // Round constant added to the running sum once per pair of half-round cells
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  typedef enum logic {
    TEA_OP_ENC = 1'b0,
    TEA_OP_DEC = 1'b1
  } tea_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD0 = 8'd0,
    REG_KEY_WORD1 = 8'd1,
    REG_KEY_WORD2 = 8'd2,
    REG_KEY_WORD3 = 8'd3
  } tea_reg_e;

  // 128-bit key as four words
  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
  } tea_key_t;

  // Block in flight along the cell row
  typedef struct packed {
    tea_op_e           op;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_data_t;

  // DELTA * cnt mod 2^32, evaluated at elaboration
  function automatic logic [WORD_W-1:0] tea_sum(input int unsigned cnt);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(cnt);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// ===== design/tea_blk_if.sv =====
`timescale 1ns / 1ps
// Input channel: one data block plus the operation select.
// Depends on tea_pkg for the word width.
interface tea_blk_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [tea_pkg::WORD_W-1:0]   block_first;
  logic [tea_pkg::WORD_W-1:0]   block_second;

  modport source (output valid, output op, output block_first, output block_second,
                  input ready);
  modport sink   (input valid, input op, input block_first, input block_second,
                  output ready);
endinterface

// ===== design/tea_res_if.sv =====
`timescale 1ns / 1ps
// Output channel: one transformed data block.
// Depends on tea_pkg for the word width.
interface tea_res_if;
  logic                         valid;
  logic                         ready;
  logic [tea_pkg::WORD_W-1:0]   result_first;
  logic [tea_pkg::WORD_W-1:0]   result_second;

  modport source (output valid, output result_first, output result_second, input ready);
  modport sink   (input valid, input result_first, input result_second, output ready);
endinterface

// ===== design/tea_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on tea_pkg for the index and word widths.
interface tea_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tea_pkg::CFG_IDX_W-1:0] index;
  logic [tea_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tea_block_cipher.sv =====
`timescale 1ns / 1ps
// TEA block cipher top level: key registers and a row of half-round cells.
// Depends on tea_pkg, tea_blk_if, tea_res_if, tea_cfg_if, tea_key_regs and tea_cell.

// Encrypts (op 0) or decrypts (op 1) one 64-bit block per transfer under the 128-bit key
// in config registers 0..3. The data path is a row of 2*CYCLE_COUNT half-round cells,
// each one register stage; a new block is taken every cycle unless a stalled output
// has filled the row. The last cell is the output register; a stalled output lets
// upstream cells keep filling until the row is full.
// Write keys only while no block is in flight.
module tea_block_cipher #(
  parameter int unsigned CYCLE_COUNT = tea_pkg::CYCLE_COUNT_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tea_cfg_if.sink cfg_i,
  tea_blk_if.sink in_i,
  tea_res_if.source out_o
);
  import tea_pkg::*;

  localparam int unsigned NCELL = 2 * CYCLE_COUNT;

  tea_key_t  key;
  logic      vld [NCELL+1];
  logic      rdy [NCELL+1];
  tea_data_t dat [NCELL+1];

  tea_key_regs u_keys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  // Row entry
  assign vld[0]     = in_i.valid;
  assign dat[0].op  = tea_op_e'(in_i.op);
  assign dat[0].y   = in_i.block_first;
  assign dat[0].z   = in_i.block_second;
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tea_cell #(
      .CELL_IDX    (k),
      .CYCLE_COUNT (CYCLE_COUNT)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .valid_i (vld[k]),
      .data_i  (dat[k]),
      .ready_o (rdy[k]),
      .valid_o (vld[k+1]),
      .data_o  (dat[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  // Row exit
  assign rdy[NCELL]          = out_o.ready;
  assign out_o.valid         = vld[NCELL];
  assign out_o.result_first  = dat[NCELL].y;
  assign out_o.result_second = dat[NCELL].z;

  // An empty first cell always takes a block
  a_first_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld[1] |-> in_i.ready)
    else $error("input stalled with empty first cell");

  // An accepted block occupies the first cell next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld[1])
    else $error("accepted block missing from first cell");

  // With both end cells full, the output stalled and the first cell unable to drain, nothing enters
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[1] && vld[NCELL] && !out_o.ready && (NCELL == 1 || !rdy[1])) |-> !in_i.ready)
    else $error("input taken while the row is blocked");

  // A drained output with a full last stage refills from the cell before it
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[NCELL] && out_o.ready && vld[NCELL-1] && NCELL > 1) |=> out_o.valid)
    else $error("result lost between last two cells");

endmodule

// ===== design/tea_key_regs.sv =====
`timescale 1ns / 1ps
// Key register file: four 32-bit key words written over the config channel.
// Depends on tea_pkg and tea_cfg_if.
module tea_key_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  tea_cfg_if.sink           cfg_i,
  output tea_pkg::tea_key_t key_o
);
  import tea_pkg::*;

  tea_key_t key_q, key_d;

  // Always ready; writes to unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KEY_WORD0: key_d.w0 = cfg_i.data;
        REG_KEY_WORD1: key_d.w1 = cfg_i.data;
        REG_KEY_WORD2: key_d.w2 = cfg_i.data;
        REG_KEY_WORD3: key_d.w3 = cfg_i.data;
        default:       key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== design/tea_cell.sv =====
`timescale 1ns / 1ps
// One half-round of TEA: a single register stage of the cell row.
// Depends on tea_pkg for types, the round constant and the sum helper.
module tea_cell #(
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned CYCLE_COUNT = tea_pkg::CYCLE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tea_pkg::tea_key_t key_i,
  input  logic              valid_i,
  input  tea_pkg::tea_data_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output tea_pkg::tea_data_t data_o,
  input  logic              ready_i
);
  import tea_pkg::*;

  // Cell position: which cycle, which half of it
  localparam int unsigned CYC      = CELL_IDX / 2;
  localparam bit          SECOND_H = (CELL_IDX % 2) == 1;
  localparam logic [WORD_W-1:0] SUM_ENC = tea_sum(CYC + 1);
  localparam logic [WORD_W-1:0] SUM_DEC = tea_sum(CYCLE_COUNT - CYC);

  logic              valid_q, valid_d;
  tea_data_t         data_q, data_d;
  logic              upd_y;
  logic [WORD_W-1:0] x, s, ka, kb, tgt, mix, nxt;

  // Encryption updates y first, decryption undoes z first
  always_comb begin
    upd_y = (data_i.op == TEA_OP_ENC) ? !SECOND_H : SECOND_H;
    x     = upd_y ? data_i.z : data_i.y;
    tgt   = upd_y ? data_i.y : data_i.z;
    ka    = upd_y ? key_i.w0 : key_i.w2;
    kb    = upd_y ? key_i.w1 : key_i.w3;
    s     = (data_i.op == TEA_OP_ENC) ? SUM_ENC : SUM_DEC;
    mix   = ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    nxt   = (data_i.op == TEA_OP_ENC) ? (tgt + mix) : (tgt - mix);
    data_d = data_i;
    if (upd_y) begin
      data_d.y = nxt;
    end else begin
      data_d.z = nxt;
    end
  end

  // Take a new transfer when empty or when the neighbor drains us
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
